### src/wdtr_pkg.sv
// Package for the watchdog timer register block: item and result types,
// register map codes, identification words and the restart key.
// Depends on nothing; every other file of the block uses it.
package wdtr_pkg;

    localparam int COUNTER_WIDTH_DEFAULT = 32;
    localparam int DATA_WIDTH            = 32;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    localparam logic [3:0] REG_CTRL    = 4'd0;
    localparam logic [3:0] REG_TORR    = 4'd1;
    localparam logic [3:0] REG_CCVR    = 4'd2;
    localparam logic [3:0] REG_CRR     = 4'd3;
    localparam logic [3:0] REG_STAT    = 4'd4;
    localparam logic [3:0] REG_EOI     = 4'd5;
    localparam logic [3:0] REG_PROT    = 4'd6;
    localparam logic [3:0] REG_PARAM2  = 4'd10;
    localparam logic [3:0] REG_PARAM1  = 4'd11;
    localparam logic [3:0] REG_VERSION = 4'd12;
    localparam logic [3:0] REG_TYPE    = 4'd13;

    localparam logic [31:0] ID_PARAM2  = 32'hFFFF_FFFF;
    localparam logic [31:0] ID_PARAM1  = 32'h2000_0E40;
    localparam logic [31:0] ID_VERSION = 32'h3131_302A;
    localparam logic [31:0] ID_TYPE    = 32'h4457_0120;

    localparam logic [7:0] RESTART_KEY   = 8'h76;
    localparam logic [2:0] PROT_RESET    = 3'd2;
    localparam logic [4:0] PERIOD_BASE   = 5'd16;

    typedef struct packed {
        t_action               action;
        logic [3:0]            reg_select;
        logic [DATA_WIDTH-1:0] write_data;
    } t_item;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic                  irq_level;
        logic                  system_reset;
    } t_result;

    typedef struct packed {
        logic running;
        logic enable;
        logic loaded;
    } t_status;

endpackage

### src/wdtr_cmd_if.sv
// Command channel of the watchdog block: one beat is a tick, read, write or no-op.
// Depends on wdtr_pkg for the action type and data width.
interface wdtr_cmd_if;
    logic                            valid;
    logic                            ready;
    wdtr_pkg::t_action               action;
    logic [3:0]                      reg_select;
    logic [wdtr_pkg::DATA_WIDTH-1:0] write_data;

    modport source (output valid, action, reg_select, write_data, input ready);
    modport sink   (input valid, action, reg_select, write_data, output ready);
endinterface

### src/wdtr_rsp_if.sv
// Response channel of the watchdog block: one beat per command beat.
// Depends on wdtr_pkg for the data width.
interface wdtr_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [wdtr_pkg::DATA_WIDTH-1:0] read_data;
    logic                            irq_level;
    logic                            system_reset;

    modport source (output valid, read_data, irq_level, system_reset, input ready);
    modport sink   (input valid, read_data, irq_level, system_reset, output ready);
endinterface

### src/wdtr_core.sv
// Register file and down-counter of the watchdog; computes one result per beat.
// Depends on wdtr_pkg for types, register codes and identification words.
module wdtr_core #(
    parameter int COUNTER_WIDTH = wdtr_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  wdtr_pkg::t_item   i_item,
    output wdtr_pkg::t_result o_result,
    output wdtr_pkg::t_status o_status
);

    localparam logic [4:0] E_MAX = 5'(COUNTER_WIDTH - 1);

    logic [4:0]               r_ctrl,    n_ctrl;
    logic [3:0]               r_psel,    n_psel;
    logic                     r_loaded,  n_loaded;
    logic                     r_int,     n_int;
    logic [2:0]               r_prot,    n_prot;
    logic [COUNTER_WIDTH-1:0] r_saved,   n_saved;
    logic [COUNTER_WIDTH-1:0] r_live,    n_live;
    logic                     r_running, n_running;
    logic [31:0]              rd;
    logic                     rst_pulse;

    // The period is a single set bit, or zero while no period is loaded; the exponent saturates at the top bit.
    function automatic logic [COUNTER_WIDTH-1:0] period_of(logic loaded, logic [3:0] psel);
        logic [4:0] e;
        e = wdtr_pkg::PERIOD_BASE + {1'b0, psel};
        if (e > E_MAX) begin
            e = E_MAX;
        end
        return loaded ? (COUNTER_WIDTH'(1) << e) : '0;
    endfunction

    always_comb begin
        n_ctrl    = r_ctrl;
        n_psel    = r_psel;
        n_loaded  = r_loaded;
        n_int     = r_int;
        n_prot    = r_prot;
        n_saved   = r_saved;
        n_live    = r_live;
        n_running = r_running;
        rd        = '0;
        rst_pulse = 1'b0;
        case (i_item.action)
            wdtr_pkg::ACT_TICK: begin
                if (r_running) begin
                    if (r_live <= COUNTER_WIDTH'(1)) begin
                        if (r_ctrl[1]) begin
                            n_int = 1'b1;
                        end else begin
                            rst_pulse = 1'b1;
                        end
                        n_saved = period_of(r_loaded, r_psel);
                        n_live  = n_saved;
                    end else begin
                        n_live = r_live - COUNTER_WIDTH'(1);
                    end
                end
            end
            wdtr_pkg::ACT_READ: begin
                case (i_item.reg_select)
                    wdtr_pkg::REG_CTRL:    rd = 32'(r_ctrl);
                    wdtr_pkg::REG_TORR:    rd = 32'(r_psel);
                    wdtr_pkg::REG_CCVR:    rd = r_ctrl[0] ? 32'(r_live) : 32'(r_saved);
                    wdtr_pkg::REG_STAT:    rd = 32'(r_int);
                    wdtr_pkg::REG_PROT:    rd = 32'(r_prot);
                    wdtr_pkg::REG_PARAM2:  rd = wdtr_pkg::ID_PARAM2;
                    wdtr_pkg::REG_PARAM1:  rd = wdtr_pkg::ID_PARAM1;
                    wdtr_pkg::REG_VERSION: rd = wdtr_pkg::ID_VERSION;
                    wdtr_pkg::REG_TYPE:    rd = wdtr_pkg::ID_TYPE;
                    default:               rd = '0;
                endcase
            end
            wdtr_pkg::ACT_WRITE: begin
                case (i_item.reg_select)
                    wdtr_pkg::REG_CTRL: begin
                        n_ctrl = i_item.write_data[4:0];
                        if (n_ctrl[0] && r_loaded) begin
                            n_live    = r_saved;
                            n_running = 1'b1;
                        end else begin
                            n_running = 1'b0;
                        end
                    end
                    wdtr_pkg::REG_TORR: begin
                        n_psel   = i_item.write_data[3:0];
                        n_loaded = 1'b1;
                        n_saved  = period_of(1'b1, n_psel);
                        if (r_ctrl[0]) begin
                            n_live    = n_saved;
                            n_running = 1'b1;
                        end
                    end
                    wdtr_pkg::REG_CRR: begin
                        if (i_item.write_data[7:0] == wdtr_pkg::RESTART_KEY) begin
                            n_saved = period_of(r_loaded, r_psel);
                            n_int   = 1'b0;
                            if (r_ctrl[0] && r_loaded) begin
                                n_live    = n_saved;
                                n_running = 1'b1;
                            end else begin
                                n_running = 1'b0;
                            end
                        end
                    end
                    wdtr_pkg::REG_EOI:  n_int  = 1'b0;
                    wdtr_pkg::REG_PROT: n_prot = i_item.write_data[2:0];
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl    <= '0;
            r_psel    <= '0;
            r_loaded  <= 1'b0;
            r_int     <= 1'b0;
            r_prot    <= wdtr_pkg::PROT_RESET;
            r_saved   <= '1;
            r_live    <= '1;
            r_running <= 1'b0;
        end else if (i_fire) begin
            r_ctrl    <= n_ctrl;
            r_psel    <= n_psel;
            r_loaded  <= n_loaded;
            r_int     <= n_int;
            r_prot    <= n_prot;
            r_saved   <= n_saved;
            r_live    <= n_live;
            r_running <= n_running;
        end
    end

    assign o_result.read_data    = rd;
    assign o_result.irq_level    = n_int;
    assign o_result.system_reset = rst_pulse;

    assign o_status.running = r_running;
    assign o_status.enable  = r_ctrl[0];
    assign o_status.loaded  = r_loaded;

endmodule

### src/watchdog_timer_regs_top.sv
// Top level of the watchdog timer register block: input and output stages
// around wdtr_core. Depends on wdtr_pkg, wdtr_cmd_if, wdtr_rsp_if and wdtr_core.
//
//  Channel  Direction  Beat carries
//  i_cmd    in         action, reg_select, write_data
//  o_rsp    out        read_data, irq_level, system_reset (one per command beat)
//
// One command beat is taken every clock while o_rsp is not stalled. Its
// response passes the input register and then the response register before
// it is presented on o_rsp.
// The counter decrement and the register decode sit in one combinational pass
// between those two registers, and that pass sets the rate of one beat a cycle.
// Reset is synchronous and active low; it clears both stage valids and restores
// the core registers to their documented reset values in the same cycle.
// When the response is stalled the stages hold, and the input stage still takes
// a beat as long as it is empty.
module watchdog_timer_regs_top #(
    parameter int COUNTER_WIDTH = wdtr_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wdtr_cmd_if.sink   i_cmd,
    wdtr_rsp_if.source o_rsp
);

    logic              r_s1_valid;
    wdtr_pkg::t_item   r_s1;
    logic              r_out_valid;
    wdtr_pkg::t_result r_out;
    logic              s1_advance;
    logic              s1_fire;
    wdtr_pkg::t_result core_res;
    wdtr_pkg::t_status core_status;

    // The first stage moves on whenever the response register is empty or
    // is being emptied in this cycle.
    assign s1_advance  = !r_out_valid || o_rsp.ready;
    assign s1_fire     = r_s1_valid && s1_advance;
    assign i_cmd.ready = !r_s1_valid || s1_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ready) begin
                r_s1_valid <= i_cmd.valid;
            end
            if (s1_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers carry no reset; the valids above qualify them.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_s1.action     <= i_cmd.action;
            r_s1.reg_select <= i_cmd.reg_select;
            r_s1.write_data <= i_cmd.write_data;
        end
        if (s1_fire) begin
            r_out <= core_res;
        end
    end

    wdtr_core #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s1_fire),
        .i_item   (r_s1),
        .o_result (core_res),
        .o_status (core_status)
    );

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.read_data    = r_out.read_data;
    assign o_rsp.irq_level    = r_out.irq_level;
    assign o_rsp.system_reset = r_out.system_reset;

    // A stalled beat in the first stage must stay put until it can move on.
    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_advance |=> r_s1_valid && $stable(r_s1))
        else $error("first stage beat changed while stalled");

    // The counter only runs while enabled and with a period loaded.
    a_run_needs_enable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_status.running |-> core_status.enable && core_status.loaded)
        else $error("counter running without enable or period");

    // A system reset pulse can only come from a timer tick.
    a_reset_on_tick : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && core_res.system_reset |-> r_s1.action == wdtr_pkg::ACT_TICK)
        else $error("system reset pulse from a non-tick beat");

    // Read data is zero for every beat that is not a read.
    a_rdata_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1.action != wdtr_pkg::ACT_READ |-> core_res.read_data == '0)
        else $error("read data nonzero outside a read");

endmodule
